// File: hdl/lsrs_pkg.sv
package lsrs_pkg;

   localparam int LINE_PIXELS = 88;
   localparam int SAMPLE_W    = 8;
   localparam int COUNT_W     = 8;
   localparam int INDEX_W     = 7;
   localparam int CSR_ADDR_W  = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_START = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_LAST   = CSR_ADDR_W'(1);

   localparam logic [COUNT_W-1:0] WINDOW_START_RESET = COUNT_W'(20);
   localparam logic [COUNT_W-1:0] FRAME_LAST_RESET   = COUNT_W'(135);
   localparam logic [COUNT_W-1:0] WINDOW_LEN         = COUNT_W'(LINE_PIXELS);

   localparam logic [SAMPLE_W-1:0] MAX_RESET = '0;
   localparam logic [SAMPLE_W-1:0] MIN_RESET = '1;

   typedef struct packed {
      logic [COUNT_W-1:0] window_start;
      logic [COUNT_W-1:0] frame_last;
   } cfg_type;

   typedef struct packed {
      logic                start_pulse;
      logic                clock_level;
      logic                frame_done;
      logic                pixel_write;
      logic [INDEX_W-1:0]  pixel_index;
      logic [SAMPLE_W-1:0] pixel_value;
      logic [SAMPLE_W-1:0] peak_max;
      logic [SAMPLE_W-1:0] peak_min;
   } rsp_type;

endpackage

// File: hdl/lsrs_if.sv
interface lsrs_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsrs_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface lsrs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          start_pulse;
   logic                          clock_level;
   logic                          frame_done;
   logic                          pixel_write;
   logic [lsrs_pkg::INDEX_W-1:0]  pixel_index;
   logic [lsrs_pkg::SAMPLE_W-1:0] pixel_value;
   logic [lsrs_pkg::SAMPLE_W-1:0] peak_max;
   logic [lsrs_pkg::SAMPLE_W-1:0] peak_min;

   modport source (output valid, output start_pulse, output clock_level, output frame_done,
                   output pixel_write, output pixel_index, output pixel_value,
                   output peak_max, output peak_min, input ready);
   modport sink   (input valid, input start_pulse, input clock_level, input frame_done,
                   input pixel_write, input pixel_index, input pixel_value,
                   input peak_max, input peak_min, output ready);
endinterface

interface lsrs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lsrs_pkg::CSR_ADDR_W-1:0] index;
   logic [lsrs_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/lsrs_csr.sv
module lsrs_csr (
   input  logic              clock,
   input  logic              reset,
   lsrs_csr_if.sink          csr_ch,
   output lsrs_pkg::cfg_type cfg
);

   lsrs_pkg::cfg_type cfg_ff;
   lsrs_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            lsrs_pkg::CSR_WINDOW_START: cfg_in.window_start = csr_ch.data;
            lsrs_pkg::CSR_FRAME_LAST:   cfg_in.frame_last   = csr_ch.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_start <= lsrs_pkg::WINDOW_START_RESET;
         cfg_ff.frame_last   <= lsrs_pkg::FRAME_LAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/lsrs_core.sv
module lsrs_core (
   input  logic              clock,
   input  logic              reset,
   input  lsrs_pkg::cfg_type cfg,
   lsrs_req_if.sink          req_ch,
   lsrs_rsp_if.source        rsp_ch
);

   logic                                s1_valid_ff, s1_valid_in;
   logic [lsrs_pkg::SAMPLE_W-1:0]       s1_sample_ff;
   logic                                out_valid_ff, out_valid_in;
   lsrs_pkg::rsp_type                   out_ff, out_in;

   logic [lsrs_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                                phase_ff, phase_in;
   logic                                start_ff, start_in;
   logic [lsrs_pkg::SAMPLE_W-1:0]       max_ff, max_in;
   logic [lsrs_pkg::SAMPLE_W-1:0]       min_ff, min_in;

   logic                                out_free;
   logic                                s1_adv;
   logic                                accept;
   logic                                done;
   logic                                in_window;
   logic [lsrs_pkg::COUNT_W-1:0]        offset;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      done     = 1'b0;

      if (count_ff <= cfg.frame_last) begin
         if (phase_ff) begin
            if (count_ff <= lsrs_pkg::COUNT_W'(1)) begin
               start_in = 1'b0;
            end
            count_in = count_ff + lsrs_pkg::COUNT_W'(1);
         end
         phase_in = ~phase_ff;
      end else begin
         count_in = '0;
         phase_in = 1'b0;
         max_in   = lsrs_pkg::MAX_RESET;
         min_in   = lsrs_pkg::MIN_RESET;
         done     = 1'b1;
      end

      if (count_in == '0 && !phase_in) begin
         start_in = 1'b1;
      end

      offset    = count_in - cfg.window_start;
      in_window = (count_in >= cfg.window_start) && (offset < lsrs_pkg::WINDOW_LEN);

      if (in_window) begin
         if (s1_sample_ff > max_in) begin
            max_in = s1_sample_ff;
         end
         if (s1_sample_ff < min_in) begin
            min_in = s1_sample_ff;
         end
      end

      out_in.start_pulse = start_in;
      out_in.clock_level = phase_in;
      out_in.frame_done  = done;
      out_in.pixel_write = in_window;
      out_in.pixel_index = in_window ? offset[lsrs_pkg::INDEX_W-1:0] : '0;
      out_in.pixel_value = in_window ? s1_sample_ff : '0;
      out_in.peak_max    = max_in;
      out_in.peak_min    = min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         start_ff     <= 1'b0;
         max_ff       <= lsrs_pkg::MAX_RESET;
         min_ff       <= lsrs_pkg::MIN_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            count_ff <= count_in;
            phase_ff <= phase_in;
            start_ff <= start_in;
            max_ff   <= max_in;
            min_ff   <= min_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_ch.sample;
      end
      if (s1_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.start_pulse = out_ff.start_pulse;
   assign rsp_ch.clock_level = out_ff.clock_level;
   assign rsp_ch.frame_done  = out_ff.frame_done;
   assign rsp_ch.pixel_write = out_ff.pixel_write;
   assign rsp_ch.pixel_index = out_ff.pixel_index;
   assign rsp_ch.pixel_value = out_ff.pixel_value;
   assign rsp_ch.peak_max    = out_ff.peak_max;
   assign rsp_ch.peak_min    = out_ff.peak_min;

endmodule

// File: hdl/line_sensor_readout_sequencer.sv
// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    sample
// rsp_ch    out        valid/ready    start_pulse, clock_level, frame_done, pixel_write,
//                                     pixel_index, pixel_value, peak_max, peak_min
// csr_ch    in         valid/ready    index, data
//
// One item is accepted every cycle unless the input register is full and the result is stalled;
// each item passes the input register and then the result register around the update logic.
// Reset is synchronous and clears the sequencer state and both valid flags.
// A stalled result holds in the result register while one more item waits in the input
// register; the configuration port is always ready.
module line_sensor_readout_sequencer (
   input logic        clock,
   input logic        reset,
   lsrs_req_if.sink   req_ch,
   lsrs_rsp_if.source rsp_ch,
   lsrs_csr_if.sink   csr_ch
);

   lsrs_pkg::cfg_type cfg;

   lsrs_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   lsrs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// File: hdl/lsrs_checker.sv
module lsrs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          start_pulse,
   input logic                          clock_level,
   input logic                          frame_done,
   input logic                          pixel_write,
   input logic [lsrs_pkg::INDEX_W-1:0]  pixel_index,
   input logic [lsrs_pkg::SAMPLE_W-1:0] pixel_value,
   input logic [lsrs_pkg::SAMPLE_W-1:0] peak_max,
   input logic [lsrs_pkg::SAMPLE_W-1:0] peak_min
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   a_frame_end_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> start_pulse && !clock_level)
      else $error("frame end without start pulse high and clock low");

   a_idle_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pixel_write |-> pixel_index == '0 && pixel_value == '0)
      else $error("pixel fields set without a write");

   a_peaks_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pixel_write |-> peak_max >= pixel_value && peak_min <= pixel_value)
      else $error("peaks do not bound the written pixel");

endmodule

bind line_sensor_readout_sequencer lsrs_checker u_lsrs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .start_pulse (rsp_ch.start_pulse),
   .clock_level (rsp_ch.clock_level),
   .frame_done  (rsp_ch.frame_done),
   .pixel_write (rsp_ch.pixel_write),
   .pixel_index (rsp_ch.pixel_index),
   .pixel_value (rsp_ch.pixel_value),
   .peak_max    (rsp_ch.peak_max),
   .peak_min    (rsp_ch.peak_min)
);
